>>> design/blinn_phong_fragment_shade_assert.svh
// Assertion macros for the shading block checker
`ifndef BLINN_PHONG_FRAGMENT_SHADE_ASSERT_SVH
`define BLINN_PHONG_FRAGMENT_SHADE_ASSERT_SVH

// same-cycle implication, idle during reset
`define BPFS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, idle during reset
`define BPFS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, active through reset
`define BPFS_ASSERT_RESET(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/bpfs_pkg.sv
// Types, constants and constant functions for the Blinn-Phong shading pipeline
package bpfs_pkg;

   localparam int SQRT_STEPS = 27;
   localparam int DIV_STEPS  = 16;
   localparam int LOG_STEPS  = 16;
   localparam int EXP_STEPS  = 20;
   localparam int NORM_LEN   = 3 + SQRT_STEPS + DIV_STEPS + 1;

   localparam int ST_N1      = 1;
   localparam int ST_N2      = ST_N1 + NORM_LEN;
   localparam int ST_DOT     = ST_N2 + NORM_LEN;
   localparam int ST_BASE    = ST_DOT + 1;
   localparam int ST_LEAD    = ST_BASE + 1;
   localparam int ST_SQ      = ST_LEAD + 1;
   localparam int ST_LOG     = ST_SQ + LOG_STEPS;
   localparam int ST_EXP     = ST_LOG + 1;
   localparam int ST_POW     = ST_EXP + EXP_STEPS;
   localparam int ST_EN1     = ST_POW + 1;
   localparam int ST_EN2     = ST_EN1 + 1;
   localparam int ST_MUL     = ST_EN2 + 1;
   localparam int ST_OUT     = ST_MUL + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic [28:0] INVPI30   = 29'd341782638;
   localparam logic [12:0] COLOR_MAX = 13'd4096;
   localparam logic [11:0] SHINE_RST = 12'd512;

   typedef enum logic [2:0] {
      REG_DIFFUSE  = 3'd0,
      REG_AMBIENT  = 3'd1,
      REG_SPECULAR = 3'd2,
      REG_SHINE    = 3'd3,
      REG_EYE      = 3'd4
   } csr_reg_type;

   typedef logic [EXP_STEPS:0][30:0] coef_tab_type;

   typedef struct packed {
      logic [2:0][15:0] nrm;
      logic [15:0]      depth;
      logic [2:0][17:0] vec;
      logic [2:0][34:0] sq;
      logic             zero;
      logic [54:0]      sx;
      logic [54:0]      sr;
      logic [26:0]      den;
      logic [2:0][41:0] rem;
      logic [2:0][15:0] quo;
      logic [2:0]       neg;
      logic [2:0][15:0] unit;
      logic [2:0][31:0] prod;
      logic [14:0]      base;
      logic [3:0]       lead;
      logic [30:0]      mant;
      logic [15:0]      frac;
      logic [11:0]      ip;
      logic [19:0]      fp;
      logic [30:0]      acc;
      logic [16:0]      p16;
      logic [29:0]      t;
      logic [17:0]      spec;
      logic [2:0][35:0] chan;
      logic [2:0][30:0] sprod;
      logic [2:0][12:0] color;
   } item_type;

   function automatic logic [63:0] isqrt_const(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bitv;
      logic [63:0] xv;
      r    = '0;
      xv   = x;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (xv >= r + bitv) begin
            xv = xv - (r + bitv);
            r  = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // c[k] = 2^(-2^-k) in Q1.30, each from the previous by a floor square root
   function automatic coef_tab_type build_coef();
      coef_tab_type c;
      logic [63:0]  v;
      v    = 64'd1 << 29;
      c[0] = 31'(v);
      for (int k = 1; k <= EXP_STEPS; k++) begin
         v    = isqrt_const(v << 30);
         c[k] = 31'(v);
      end
      return c;
   endfunction

   localparam coef_tab_type EXP_COEF = build_coef();

endpackage

>>> design/blinn_phong_fragment_shade.sv
// Blinn-Phong fragment shading pipeline with an APB register port
// Usage: fragments enter on the req_ stream (normal x,y,z in Q1.14 and position x,y,z),
// one shaded color plus depth leaves on the rsp_ stream for every fragment, in order.
// Material colors, shininess and eye position sit in APB registers at byte address
// 8*index; the user must write them while no fragment is in flight, unenforced by the block.
// Throughput: one fragment per clock while rsp_ is not stalled. The latency from a req_
// transfer to the rsp_ result is set by the two bit-serial square roots (27 stages each), the two
// restoring divisions (16 stages each), 16 squaring stages of the log and 20 product
// stages of the exp2.
// The pipeline moves as one: every stage advances when the output stage is empty or
// its result is taken, so a stalled receiver holds all stages and req_tready falls
// only while the output holds an untaken result.
// Reset clears every stage valid bit and restores the registers (shininess 32.0, all
// else 0); data registers are not cleared.
module blinn_phong_fragment_shade (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // normal_x, normal_y, normal_z, pos_x, pos_y, pos_z (16 bits each, low to high)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[12:0], green[25:13], blue[38:26], depth[54:39], zero pad
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import bpfs_pkg::*;

   logic [38:0] diffuse_ff, ambient_ff, specular_ff;
   logic [11:0] shine_ff;
   logic [47:0] eye_ff;

   item_type                stg_in [NUM_STAGES];
   item_type                stg_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0]   vld_ff;
   logic                    adv;
   csr_reg_type             wr_reg;
   csr_reg_type             rd_reg;

   assign csr_pready = 1'b1;
   assign wr_reg     = csr_reg_type'(csr_paddr[5:3]);
   assign rd_reg     = csr_reg_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         diffuse_ff  <= '0;
         ambient_ff  <= '0;
         specular_ff <= '0;
         shine_ff    <= SHINE_RST;
         eye_ff      <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (wr_reg)
            REG_DIFFUSE:  diffuse_ff  <= csr_pwdata[38:0];
            REG_AMBIENT:  ambient_ff  <= csr_pwdata[38:0];
            REG_SPECULAR: specular_ff <= csr_pwdata[38:0];
            REG_SHINE:    shine_ff    <= csr_pwdata[11:0];
            REG_EYE:      eye_ff      <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (rd_reg)
         REG_DIFFUSE:  csr_prdata = 64'(diffuse_ff);
         REG_AMBIENT:  csr_prdata = 64'(ambient_ff);
         REG_SPECULAR: csr_prdata = 64'(specular_ff);
         REG_SHINE:    csr_prdata = 64'(shine_ff);
         REG_EYE:      csr_prdata = 64'(eye_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // normalize one vector: squares, sum, bit-serial root, per-lane restoring divide, clamp
   function automatic item_type norm_step(item_type it, int j, logic to_half);
      item_type    o;
      logic [36:0] sum;
      logic [54:0] bitv;
      logic [54:0] trial;
      logic [41:0] dsh;
      logic [16:0] mag;
      logic [15:0] q;
      logic [15:0] u;
      o = it;
      if (j == 0) begin
         for (int l = 0; l < 3; l++)
            o.sq[l] = 35'($signed(it.vec[l]) * $signed(it.vec[l]));
      end else if (j == 1) begin
         sum    = 37'(it.sq[0]) + 37'(it.sq[1]) + 37'(it.sq[2]);
         o.zero = (sum == '0);
         o.sx   = 55'({sum, 20'd0});
         o.sr   = '0;
      end else if (j < 2 + SQRT_STEPS) begin
         bitv  = 55'(1) << (2 * (SQRT_STEPS - 1) - 2 * (j - 2));
         trial = it.sr + bitv;
         if (it.sx >= trial) begin
            o.sx = it.sx - trial;
            o.sr = (it.sr >> 1) + bitv;
         end else begin
            o.sr = it.sr >> 1;
         end
      end else if (j == 2 + SQRT_STEPS) begin
         o.den = it.sr[26:0];
         for (int l = 0; l < 3; l++) begin
            o.neg[l] = it.vec[l][17];
            mag      = it.vec[l][17] ? 17'(-$signed(it.vec[l])) : it.vec[l][16:0];
            o.rem[l] = 42'({mag, 24'd0}) + 42'(it.sr[26:1]);
            o.quo[l] = '0;
         end
      end else if (j < 3 + SQRT_STEPS + DIV_STEPS) begin
         dsh = 42'(it.den) << (DIV_STEPS - 1 - (j - 3 - SQRT_STEPS));
         for (int l = 0; l < 3; l++) begin
            if (it.rem[l] >= dsh) begin
               o.rem[l] = it.rem[l] - dsh;
               o.quo[l][DIV_STEPS - 1 - (j - 3 - SQRT_STEPS)] = 1'b1;
            end
         end
      end else begin
         for (int l = 0; l < 3; l++) begin
            q = (it.quo[l] > 16'd16384) ? 16'd16384 : it.quo[l];
            u = it.zero ? 16'd0 : (it.neg[l] ? 16'(-q) : q);
            o.unit[l] = u;
            o.vec[l]  = 18'($signed(u));
         end
         if (to_half)
            o.vec[2] = 18'($signed(o.unit[2])) + 18'd16384;
      end
      return o;
   endfunction

   function automatic item_type shade_step(item_type it, int i, logic [11:0] sh,
                                           logic [38:0] dcol, logic [38:0] acol,
                                           logic [38:0] scol);
      item_type           o;
      logic signed [33:0] dsum;
      logic [33:0]        rb;
      logic [3:0]         ld;
      logic [61:0]        sqr;
      logic [31:0]        m2;
      logic [19:0]        neglog;
      logic [31:0]        xv;
      logic [61:0]        pr;
      logic [32:0]        rsum;
      logic [58:0]        big;
      logic [14:0]        diff;
      logic [35:0]        tot;
      logic [21:0]        ch;
      o = it;
      if (i == ST_DOT) begin
         for (int l = 0; l < 3; l++)
            o.prod[l] = 32'($signed(it.nrm[l]) * $signed(it.unit[l]));
      end else if (i == ST_BASE) begin
         dsum = 34'($signed(it.prod[0])) + 34'($signed(it.prod[1]))
              + 34'($signed(it.prod[2]));
         rb   = 34'(dsum + 34'sd8192) >> 14;
         if (dsum <= 0)
            o.base = '0;
         else if (rb > 34'd16384)
            o.base = 15'd16384;
         else
            o.base = rb[14:0];
      end else if (i == ST_LEAD) begin
         ld = '0;
         for (int b = 0; b < 15; b++)
            if (it.base[b]) ld = 4'(b);
         o.lead = ld;
         o.mant = 31'(it.base) << (5'd30 - 5'(ld));
         o.frac = '0;
      end else if (i < ST_LOG) begin
         sqr = 62'(it.mant) * 62'(it.mant);
         m2  = sqr[61:30];
         if (m2[31]) begin
            o.mant = m2[31:1];
            o.frac = {it.frac[14:0], 1'b1};
         end else begin
            o.mant = m2[30:0];
            o.frac = {it.frac[14:0], 1'b0};
         end
      end else if (i == ST_LOG) begin
         neglog = {4'(4'd14 - it.lead), 16'd0} - 20'(it.frac);
         xv     = 32'(neglog) * 32'(sh);
         o.ip   = xv[31:20];
         o.fp   = xv[19:0];
         o.acc  = 31'(1) << 30;
      end else if (i < ST_POW) begin
         if (it.fp[EXP_STEPS - 1 - (i - ST_EXP)]) begin
            pr    = 62'(it.acc) * 62'(EXP_COEF[i - ST_EXP + 1]) + (62'(1) << 29);
            o.acc = pr[60:30];
         end
      end else if (i == ST_POW) begin
         rsum = 33'(it.acc) + (33'(1) << (5'd13 + it.ip[4:0]));
         if (sh == '0)
            o.p16 = 17'd65536;
         else if (it.base == '0 || it.ip > 12'd16)
            o.p16 = '0;
         else
            o.p16 = 17'(rsum >> (5'd14 + it.ip[4:0]));
      end else if (i == ST_EN1) begin
         o.t = 30'(it.p16) * 30'(13'(sh) + 13'd128);
      end else if (i == ST_EN2) begin
         big    = 59'(it.t) * 59'(INVPI30) + (59'(1) << 40);
         o.spec = 18'(big >> 41);
      end else if (i == ST_MUL) begin
         diff = it.nrm[2][15] ? 15'd0 : it.nrm[2][14:0];
         for (int l = 0; l < 3; l++) begin
            o.chan[l]  = 36'(dcol[13*l +: 13]) * 36'(diff);
            o.sprod[l] = 31'(scol[13*l +: 13]) * 31'(it.spec);
         end
      end else begin
         for (int l = 0; l < 3; l++) begin
            tot = it.chan[l] + {9'd0, acol[13*l +: 13], 14'd0}
                + {3'd0, it.sprod[l], 2'd0} + 36'd8192;
            ch  = tot[35:14];
            o.color[l] = (ch > 22'(COLOR_MAX)) ? COLOR_MAX : ch[12:0];
         end
      end
      return o;
   endfunction

   // stage 0: eye minus position and capture of the normal and depth
   always_comb begin
      stg_in[0]       = stg_ff[0];
      stg_in[0].depth = req_tdata[95:80];
      for (int l = 0; l < 3; l++) begin
         stg_in[0].nrm[l] = req_tdata[16*l +: 16];
         stg_in[0].vec[l] = 18'($signed(eye_ff[16*l +: 16]))
                          - 18'($signed(req_tdata[48 + 16*l +: 16]));
      end
   end

   for (genvar i = 1; i < NUM_STAGES; i++) begin : g_stage
      if (i < ST_N2) begin : g_view
         always_comb stg_in[i] = norm_step(stg_ff[i-1], i - ST_N1, 1'b1);
      end else if (i < ST_DOT) begin : g_half
         always_comb stg_in[i] = norm_step(stg_ff[i-1], i - ST_N2, 1'b0);
      end else begin : g_shade
         always_comb stg_in[i] = shade_step(stg_ff[i-1], i, shine_ff, diffuse_ff,
                                            ambient_ff, specular_ff);
      end
   end

   // advance all stages together unless the output holds an untaken result
   assign adv        = !vld_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (adv)
         stg_ff <= stg_in;
   end

   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = {1'b0, stg_ff[NUM_STAGES-1].depth, stg_ff[NUM_STAGES-1].color[2],
                        stg_ff[NUM_STAGES-1].color[1], stg_ff[NUM_STAGES-1].color[0]};

endmodule

>>> design/bpfs_checker.sv
// Port-level checker for the shading block, bound to the top level
module bpfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   import bpfs_pkg::*;

`include "blinn_phong_fragment_shade_assert.svh"

   logic color_ok;

   assign color_ok = (rsp_tdata[12:0] <= COLOR_MAX) && (rsp_tdata[25:13] <= COLOR_MAX)
                  && (rsp_tdata[38:26] <= COLOR_MAX);

   `BPFS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BPFS_ASSERT_IMPL(a_color_range, rsp_tvalid, color_ok)
   `BPFS_ASSERT_IMPL(a_accept_free, !rsp_tvalid || rsp_tready, req_tready)
   `BPFS_ASSERT_RESET(a_reset_empty, reset, !rsp_tvalid)

endmodule

bind blinn_phong_fragment_shade bpfs_checker u_bpfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
